// ===== design/rtmpp_pkg.sv =====
// Shared types, constants and helper functions for the packed pixel unit.
package rtmpp_pkg;

  localparam int unsigned FIFO_AW    = 1;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIX_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST  = 3'd4;

  localparam logic [31:0] RED_MASK_RESET   = 32'h0000_F800;
  localparam logic [31:0] GREEN_MASK_RESET = 32'h0000_07E0;
  localparam logic [31:0] BLUE_MASK_RESET  = 32'h0000_001F;
  localparam logic [2:0]  PIX_BYTES_RESET  = 3'd2;
  localparam logic [2:0]  PIX_BYTES_MIN    = 3'd2;
  localparam logic [2:0]  PIX_BYTES_MAX    = 3'd4;

  localparam logic [7:0] OPAQUE_LIMIT = 8'd128;
  localparam logic [7:0] FULL_BYTE    = 8'hFF;

  typedef struct packed {
    logic       en;
    logic [4:0] lo;
    logic [2:0] shr;
  } chan_t;

  typedef struct packed {
    chan_t      red;
    chan_t      green;
    chan_t      blue;
    logic [2:0] nbytes;
    logic       msb_first;
  } cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic        opaque;
  } entry_t;

  function automatic chan_t chan_fields(input logic [31:0] m);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [4:0] span;
    chan_t      c;
    lo = 5'd0;
    hi = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (m[b]) lo = 5'(b);
    end
    for (int b = 0; b < 32; b++) begin
      if (m[b]) hi = 5'(b);
    end
    span  = hi - lo;
    c.en  = |m;
    c.lo  = lo;
    c.shr = (span >= 5'd7) ? 3'd0 : 3'(5'd7 - span);
    return c;
  endfunction

  function automatic logic [31:0] place_channel(input logic [7:0] ch, input chan_t c);
    logic [7:0] cut;
    cut = ch >> c.shr;
    return c.en ? ({24'd0, cut} << c.lo) : 32'd0;
  endfunction

  function automatic logic [2:0] clamp_bytes(input logic [2:0] v);
    logic [2:0] n;
    n = v;
    if (v < PIX_BYTES_MIN) n = PIX_BYTES_MIN;
    if (v > PIX_BYTES_MAX) n = PIX_BYTES_MAX;
    return n;
  endfunction

endpackage

// ===== design/rtmpp_cfg.sv =====
// Configuration register file holding the decoded channel fields, pixel byte count and byte order.
module rtmpp_cfg
  import rtmpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RED_MASK:   cfg_nxt.red       = chan_fields(cfg_data);
        CFG_GREEN_MASK: cfg_nxt.green     = chan_fields(cfg_data);
        CFG_BLUE_MASK:  cfg_nxt.blue      = chan_fields(cfg_data);
        CFG_PIX_BYTES:  cfg_nxt.nbytes    = clamp_bytes(cfg_data[2:0]);
        CFG_MSB_FIRST:  cfg_nxt.msb_first = cfg_data[0];
        default:        cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red       <= chan_fields(RED_MASK_RESET);
      cfg_r.green     <= chan_fields(GREEN_MASK_RESET);
      cfg_r.blue      <= chan_fields(BLUE_MASK_RESET);
      cfg_r.nbytes    <= PIX_BYTES_RESET;
      cfg_r.msb_first <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/rtmpp_front.sv =====
// Front end that packs the colour channels into a pixel word and classifies opacity.
module rtmpp_front
  import rtmpp_pkg::*;
(
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] alpha,
  input  cfg_t       cfg,
  output entry_t     entry
);

  assign entry.word   = place_channel(red, cfg.red)
                      | place_channel(green, cfg.green)
                      | place_channel(blue, cfg.blue);
  assign entry.opaque = alpha > OPAQUE_LIMIT;

endmodule

// ===== design/rtmpp_fifo.sv =====
// Short queue of packed pixels between the front end and the byte serializer.
module rtmpp_fifo
  import rtmpp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wr_data,
  input  logic   pop,
  output entry_t rd_data,
  output logic   empty,
  output logic   full
);

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic [FIFO_AW:0]   count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/rtmpp_back.sv =====
// Back end that serializes each packed pixel into masked output bytes.
module rtmpp_back
  import rtmpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  entry_t     q_data,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_image_byte,
  output logic [7:0] out_mask_byte,
  output logic       out_last_byte
);

  entry_t     cur_r;
  logic       cur_valid_r;
  logic [1:0] k_r;
  logic       out_valid_r;
  logic [7:0] image_r;
  logic [7:0] mask_r;
  logic       last_r;

  logic       out_free;
  logic       emit;
  logic       last;
  logic [2:0] pos_full;
  logic [1:0] pos;
  logic [7:0] sel_byte;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cur_valid_r && out_free;
  assign last     = ({1'b0, k_r} == (cfg.nbytes - 3'd1));
  assign q_pop    = !q_empty && (!cur_valid_r || (emit && last));
  assign pos_full = cfg.msb_first ? (cfg.nbytes - 3'd1 - {1'b0, k_r}) : {1'b0, k_r};
  assign pos      = pos_full[1:0];

  always_comb begin
    unique case (pos)
      2'd0: sel_byte = cur_r.word[7:0];
      2'd1: sel_byte = cur_r.word[15:8];
      2'd2: sel_byte = cur_r.word[23:16];
      2'd3: sel_byte = cur_r.word[31:24];
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (emit) begin
      image_r <= cur_r.opaque ? sel_byte : 8'd0;
      mask_r  <= cur_r.opaque ? 8'd0 : FULL_BYTE;
      last_r  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        k_r         <= 2'd0;
      end else if (emit && last) begin
        cur_valid_r <= 1'b0;
      end else if (emit) begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_image_byte = image_r;
  assign out_mask_byte  = mask_r;
  assign out_last_byte  = last_r;

endmodule

// ===== design/rgb_to_masked_packed_pixel_unit.sv =====
// Top level of the RGBA to masked packed pixel unit.
// Each accepted pixel yields pixel_bytes output beats (2 to 4), one per cycle while out_stall
// is low; the back end byte serializer loads the next queued pixel as the last beat is emitted.
// Pixels are accepted one per cycle into a two-entry queue until it fills, and the front
// end keeps accepting while a finished beat waits in the output register. Configuration is
// always ready and must be written only while no pixel is in flight.
module rgb_to_masked_packed_pixel_unit
  import rtmpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_alpha,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_image_byte,
  output logic [7:0]           out_mask_byte,
  output logic                 out_last_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t   cfg;
  entry_t front_entry;
  entry_t q_data;
  logic   q_empty;
  logic   q_full;
  logic   q_pop;
  logic   q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  rtmpp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtmpp_front u_front (
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .alpha (in_alpha),
    .cfg   (cfg),
    .entry (front_entry)
  );

  rtmpp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (front_entry),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty),
    .full    (q_full)
  );

  rtmpp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_data         (q_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_image_byte (out_image_byte),
    .out_mask_byte  (out_mask_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ===== design/rtmpp_checker.sv =====
// Port-level checker for the packed pixel unit and its bind to the top level.
module rtmpp_checker
  import rtmpp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_image_byte,
  input logic [7:0] out_mask_byte,
  input logic       out_last_byte
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output beat shown right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_image_byte)
      && $stable(out_mask_byte) && $stable(out_last_byte))
    else $error("Stalled output beat changed.");

  a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mask_byte == 8'd0 || out_mask_byte == FULL_BYTE))
    else $error("Mask byte is neither clear nor full.");

  a_transparent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mask_byte == FULL_BYTE |-> out_image_byte == 8'd0)
    else $error("Transparent beat carries a nonzero image byte.");

endmodule

bind rgb_to_masked_packed_pixel_unit rtmpp_checker u_rtmpp_checker (.*);
